// ----- design/assert_macros.svh -----
// Assertion macros for the design files; the allocator top level includes them.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/lrueo_pkg.sv -----
// Shared types and constants for the LRU order allocator.
// No dependencies.
package lrueo_pkg;

	localparam int FUNC_W         = 2;
	localparam int PIECE_W        = 4;
	localparam int MASK_W         = 16;
	localparam int DEF_NUM_PIECES = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_TOUCH   = 2'd1,
		FUNC_RELEASE = 2'd2
	} func_t;

	// command broadcast to every cell of the order row
	typedef struct packed {
		logic               exec;
		logic [FUNC_W-1:0]  op;
		logic [PIECE_W-1:0] idx;
		logic [MASK_W-1:0]  mask;
	} cell_cmd_t;

endpackage

// ----- design/lrueo_req_if.sv -----
// Request channel: valid/ready handshake with operation, piece and mask.
// Depends on lrueo_pkg.
interface lrueo_req_if;
	logic                           valid;
	logic                           ready;
	logic [lrueo_pkg::FUNC_W-1:0]   func;
	logic [lrueo_pkg::PIECE_W-1:0]  piece_index;
	logic [lrueo_pkg::MASK_W-1:0]   evictable_mask;

	modport source (output valid, func, piece_index, evictable_mask, input ready);
	modport sink   (input valid, func, piece_index, evictable_mask, output ready);
endinterface

// ----- design/lrueo_rsp_if.sv -----
// Response channel: valid/ready handshake with found flag and piece index.
// Depends on lrueo_pkg.
interface lrueo_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [lrueo_pkg::PIECE_W-1:0]  piece;

	modport source (output valid, found, piece, input ready);
	modport sink   (input valid, found, piece, output ready);
endinterface

// ----- design/lru_order_evict_allocator.sv -----
// Channel | dir | handshake   | payload
// req     | in  | valid/ready | func, piece_index, evictable_mask
// rsp     | out | valid/ready | found, piece
//
// Each request is first registered; the cell row then matches it, picks the
// first hit from the least-recent end and shifts the order. A new request is
// taken only after the previous one has gone through the row; a response
// waiting in the output register does not block taking the next request.
// The row only updates when the output register is free or being drained.
// Reset loads position p with piece p; no clearing pass.
//
// Top level: row of lrueo_cell plus request and response registers.
// Depends on lrueo_pkg, lrueo_req_if, lrueo_rsp_if, lrueo_cell, assert_macros.svh.
`include "assert_macros.svh"
module lru_order_evict_allocator #(
	parameter int NUM_PIECES = lrueo_pkg::DEF_NUM_PIECES
) (
	input  logic  clk,
	input  logic  arst_n,
	lrueo_req_if.sink   req,
	lrueo_rsp_if.source rsp
);
	import lrueo_pkg::*;

	localparam int ENTRY_W = $clog2(NUM_PIECES);
	localparam int CMP_W   = (ENTRY_W > PIECE_W) ? ENTRY_W : PIECE_W;

	logic               busy_q;
	logic [FUNC_W-1:0]  op_s1;
	logic [PIECE_W-1:0] idx_s1;
	logic [MASK_W-1:0]  mask_s1;
	logic               out_valid_q;
	logic               out_found_q;
	logic [PIECE_W-1:0] out_piece_q;

	logic               exec;
	cell_cmd_t          cmd;
	logic               res_found;
	logic [PIECE_W-1:0] res_piece;
	logic [CMP_W-1:0]   ext_tail;

	logic [ENTRY_W-1:0] entry     [NUM_PIECES];
	logic [ENTRY_W-1:0] left_w    [NUM_PIECES];
	logic [ENTRY_W-1:0] right_w   [NUM_PIECES];
	logic               fwd_seen  [NUM_PIECES+1];
	logic [ENTRY_W-1:0] fwd_val   [NUM_PIECES+1];
	logic               bwd_seen  [NUM_PIECES+1];

	assign req.ready = !busy_q;
	assign exec      = busy_q && (!out_valid_q || rsp.ready);

	assign cmd.exec = exec;
	assign cmd.op   = op_s1;
	assign cmd.idx  = idx_s1;
	assign cmd.mask = mask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.func;
			idx_s1  <= req.piece_index;
			mask_s1 <= req.evictable_mask;
		end
	end

	// order row; the selected piece leaves its place and re-enters at one end
	assign fwd_seen[0]          = 1'b0;
	assign fwd_val[0]           = '0;
	assign bwd_seen[NUM_PIECES] = 1'b0;

	for (genvar p = 0; p < NUM_PIECES; p++) begin : g_cell
		if (p == 0) begin : g_first
			assign left_w[p] = fwd_val[NUM_PIECES];
		end else begin : g_mid_l
			assign left_w[p] = entry[p-1];
		end
		if (p == NUM_PIECES - 1) begin : g_last
			assign right_w[p] = fwd_val[NUM_PIECES];
		end else begin : g_mid_r
			assign right_w[p] = entry[p+1];
		end

		lrueo_cell #(
			.ENTRY_W  (ENTRY_W),
			.CELL_POS (p)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.fwd_seen_in  (fwd_seen[p]),
			.fwd_val_in   (fwd_val[p]),
			.fwd_seen_out (fwd_seen[p+1]),
			.fwd_val_out  (fwd_val[p+1]),
			.bwd_seen_in  (bwd_seen[p+1]),
			.bwd_seen_out (bwd_seen[p]),
			.left_entry   (left_w[p]),
			.right_entry  (right_w[p]),
			.entry        (entry[p])
		);
	end

	assign ext_tail = CMP_W'(fwd_val[NUM_PIECES]);

	always_comb begin
		unique case (op_s1) inside
			FUNC_ALLOC: begin
				res_found = fwd_seen[NUM_PIECES];
				res_piece = fwd_seen[NUM_PIECES] ? ext_tail[PIECE_W-1:0] : '0;
			end
			FUNC_TOUCH, FUNC_RELEASE: begin
				res_found = fwd_seen[NUM_PIECES];
				res_piece = idx_s1;
			end
			default: begin
				res_found = 1'b0;
				res_piece = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_found_q <= res_found;
			out_piece_q <= res_piece;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.piece = out_piece_q;

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, req.valid && req.ready, busy_q)
	`ASSERT_NEXT(a_exec_result, clk, arst_n, exec, out_valid_q && !busy_q)
	// every existing piece sits somewhere in the order
	`ASSERT_NEXT(a_named_found, clk, arst_n, exec && (op_s1 == FUNC_TOUCH || op_s1 == FUNC_RELEASE) && (int'(idx_s1) < NUM_PIECES), out_found_q)
	`ASSERT_NEXT(a_piece0_alloc, clk, arst_n, exec && op_s1 == FUNC_ALLOC && mask_s1[0], out_found_q)

endmodule

// ----- design/lrueo_cell.sv -----
// One position of the recency order row: holds a piece index, matches it
// against the command and shifts toward either neighbor. Depends on lrueo_pkg.
module lrueo_cell #(
	parameter int ENTRY_W  = 4,
	parameter int CELL_POS = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrueo_pkg::cell_cmd_t  cmd,
	input  logic                  fwd_seen_in,
	input  logic [ENTRY_W-1:0]    fwd_val_in,
	output logic                  fwd_seen_out,
	output logic [ENTRY_W-1:0]    fwd_val_out,
	input  logic                  bwd_seen_in,
	output logic                  bwd_seen_out,
	input  logic [ENTRY_W-1:0]    left_entry,
	input  logic [ENTRY_W-1:0]    right_entry,
	output logic [ENTRY_W-1:0]    entry
);
	import lrueo_pkg::*;

	localparam int CMP_W = (ENTRY_W > PIECE_W) ? ENTRY_W : PIECE_W;

	logic [ENTRY_W-1:0] entry_q;
	logic [CMP_W-1:0]   ext_entry;
	logic [CMP_W-1:0]   ext_idx;
	logic               mask_hit;
	logic               hit;

	assign ext_entry = CMP_W'(entry_q);
	assign ext_idx   = CMP_W'(cmd.idx);
	// pieces beyond the mask width are never evictable
	assign mask_hit  = ((ext_entry >> PIECE_W) == '0) && cmd.mask[ext_entry[PIECE_W-1:0]];

	always_comb begin
		unique case (cmd.op) inside
			FUNC_ALLOC:                 hit = mask_hit;
			FUNC_TOUCH, FUNC_RELEASE:   hit = (ext_entry == ext_idx);
			default:                    hit = 1'b0;
		endcase
	end

	// first hit from the least-recent end wins
	assign fwd_seen_out = fwd_seen_in | hit;
	assign fwd_val_out  = fwd_seen_in ? fwd_val_in : entry_q;
	assign bwd_seen_out = bwd_seen_in | hit;
	assign entry        = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENTRY_W'(CELL_POS);
		end else if (cmd.exec) begin
			if (cmd.op == FUNC_RELEASE) begin
				if (bwd_seen_out) begin
					entry_q <= left_entry;
				end
			end else if (cmd.op == FUNC_ALLOC || cmd.op == FUNC_TOUCH) begin
				if (fwd_seen_out) begin
					entry_q <= right_entry;
				end
			end
		end
	end

endmodule

// ----- bench/tb_lru_order_evict_allocator.sv -----
// Self-checking bench for lru_order_evict_allocator: directed table, then random requests.
// Keeps its own recency order and checks every response in order.
// Depends on lrueo_pkg, lrueo_req_if, lrueo_rsp_if and the allocator RTL.
module tb_lru_order_evict_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import lrueo_pkg::*;

	localparam int NUM_PIECES = 16;
	localparam int RANDOM_REQS = 1830;
	localparam int MAX_WAIT = 17;
	localparam int REPORT_LIMIT = 10;
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic               found;
		logic [PIECE_W-1:0] piece;
	} lru_rsp_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [PIECE_W-1:0] idx;
		logic [MASK_W-1:0]  mask;
		logic               typed;
		logic               exp_found;
		logic [PIECE_W-1:0] exp_piece;
	} dir_row_t;

	localparam int DIR_ROWS = 22;

	// typed rows carry the response by hand; the rest go through the predictor
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{FUNC_ALLOC,   4'h0, 16'h0000, 1'b1, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'hF, 16'hFFFF, 1'b1, 1'b1, 4'h0},
		'{FUNC_SPARE,   4'hF, 16'hFFFF, 1'b1, 1'b0, 4'h0},
		'{FUNC_SPARE,   4'h0, 16'h0000, 1'b1, 1'b0, 4'h0},
		'{FUNC_TOUCH,   4'hF, 16'h0000, 1'b1, 1'b1, 4'hF},
		'{FUNC_RELEASE, 4'hF, 16'hFFFF, 1'b1, 1'b1, 4'hF},
		'{FUNC_RELEASE, 4'h0, 16'h0000, 1'b1, 1'b1, 4'h0},
		'{FUNC_ALLOC,   4'h3, 16'h8000, 1'b1, 1'b1, 4'hF},
		'{FUNC_ALLOC,   4'h0, 16'h0001, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'h5, 16'hFFFF, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'hA, 16'hAAAA, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'h5, 16'h5555, 1'b0, 1'b0, 4'h0},
		'{FUNC_TOUCH,   4'h7, 16'hFFFF, 1'b0, 1'b0, 4'h0},
		'{FUNC_RELEASE, 4'h3, 16'h0000, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'hC, 16'h0088, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'h1, 16'h0008, 1'b0, 1'b0, 4'h0},
		'{FUNC_TOUCH,   4'h0, 16'h7FFF, 1'b0, 1'b0, 4'h0},
		'{FUNC_RELEASE, 4'h9, 16'hFFFE, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'h6, 16'hFFFF, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'h9, 16'h0000, 1'b0, 1'b0, 4'h0},
		'{FUNC_SPARE,   4'h5, 16'h1234, 1'b0, 1'b0, 4'h0},
		'{FUNC_ALLOC,   4'hE, 16'hC000, 1'b0, 1'b0, 4'h0}
	};

	logic clk = 1'b0;
	logic arst_n;

	lrueo_req_if req_ch ();
	lrueo_rsp_if rsp_ch ();

	lru_order_evict_allocator #(.NUM_PIECES(NUM_PIECES)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// position 0 is least recent
	logic [PIECE_W-1:0] lru_order [NUM_PIECES];
	lru_rsp_t pending_rsp [$];

	int mismatches = 0;
	int reqs_sent = 0;
	int rsps_checked = 0;
	int alloc_hits = 0;
	int alloc_misses = 0;
	int req_burst = 0;
	int rsp_burst = 0;

	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			burst = $urandom_range(5, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void lru_move(input int pos, input bit to_mru);
		logic [PIECE_W-1:0] v;
		v = lru_order[pos];
		if (to_mru) begin
			for (int p = pos; p < NUM_PIECES - 1; p++)
				lru_order[p] = lru_order[p + 1];
			lru_order[NUM_PIECES - 1] = v;
		end else begin
			for (int p = pos; p > 0; p--)
				lru_order[p] = lru_order[p - 1];
			lru_order[0] = v;
		end
	endfunction

	function automatic lru_rsp_t lru_apply(input logic [FUNC_W-1:0] func,
			input logic [PIECE_W-1:0] idx, input logic [MASK_W-1:0] mask);
		lru_rsp_t r;
		int pos;
		r = '0;
		pos = -1;
		case (func) inside
			FUNC_ALLOC: begin
				for (int p = 0; p < NUM_PIECES; p++) begin
					if (pos < 0 && mask[lru_order[p]])
						pos = p;
				end
				if (pos >= 0) begin
					r.found = 1'b1;
					r.piece = lru_order[pos];
					lru_move(pos, 1'b1);
				end
			end
			FUNC_TOUCH, FUNC_RELEASE: begin
				r.piece = idx;
				if (int'(idx) < NUM_PIECES) begin
					for (int p = 0; p < NUM_PIECES; p++) begin
						if (pos < 0 && lru_order[p] == idx)
							pos = p;
					end
					if (pos >= 0) begin
						lru_move(pos, func == FUNC_TOUCH);
						r.found = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [FUNC_W-1:0] func, input logic [PIECE_W-1:0] idx,
			input logic [MASK_W-1:0] mask, input logic typed, input lru_rsp_t typed_rsp);
		int gap;
		lru_rsp_t predicted;
		gap = draw_wait(req_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.func           <= func;
		req_ch.piece_index    <= idx;
		req_ch.evictable_mask <= mask;
		do @(posedge clk); while (!req_ch.ready);
		predicted = lru_apply(func, idx, mask);
		if (func == FUNC_ALLOC) begin
			if (predicted.found)
				alloc_hits++;
			else
				alloc_misses++;
		end
		pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : predicted);
		reqs_sent++;
	endtask

	function automatic logic [MASK_W-1:0] draw_mask();
		logic [MASK_W-1:0] m;
		case ($urandom_range(0, 9))
			0: m = '0;
			1: m = '1;
			2, 3, 4: m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
			5, 6: m = (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
				| (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
				| (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
			default: m = MASK_W'($urandom);
		endcase
		return m;
	endfunction

	// response side: random stalls, in-order compare
	initial begin
		int stall;
		lru_rsp_t want;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(rsp_burst);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			rsps_checked++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected response: found=%b piece=%0d",
						rsp_ch.found, rsp_ch.piece);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.found !== want.found || rsp_ch.piece !== want.piece) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("response %0d mismatch: expected found=%b piece=%0d, got found=%b piece=%0d",
							rsps_checked, want.found, want.piece, rsp_ch.found, rsp_ch.piece);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d requests sent, %0d responses pending",
			reqs_sent, pending_rsp.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int sel;
		logic [FUNC_W-1:0] func;
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.func           <= FUNC_ALLOC;
		req_ch.piece_index    <= '0;
		req_ch.evictable_mask <= '0;
		for (int p = 0; p < NUM_PIECES; p++)
			lru_order[p] = PIECE_W'(p);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].mask,
				dir_rows[i].typed, '{dir_rows[i].exp_found, dir_rows[i].exp_piece});

		// mostly allocates, with touch/release reshaping the order and some spare-function requests
		for (int n = 0; n < RANDOM_REQS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				func = FUNC_ALLOC;
			else if (sel < 75)
				func = FUNC_TOUCH;
			else if (sel < 95)
				func = FUNC_RELEASE;
			else
				func = FUNC_SPARE;
			send_request(func, PIECE_W'($urandom_range(0, 15)), draw_mask(), 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		wait (pending_rsp.size() == 0);
		repeat (10) @(posedge clk);

		$display("%0d requests, %0d responses checked; allocates: %0d hits, %0d misses",
			reqs_sent, rsps_checked, alloc_hits, alloc_misses);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
